// ===== rtl/core/bcs_pkg.sv =====
package bcs_pkg;

	localparam int COORD_W = 32;
	localparam int BASIS_BITS = 30;
	localparam int BASIS_W = BASIS_BITS + 2;
	localparam int ACC_W = 64;
	localparam int SC_MAX = 64;
	localparam int SC_W = 7;
	localparam int D_W = 6;
	localparam int DEG_W = 3;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam int MAX_POINTS_DEF = 32;
	localparam int MAX_DEGREE_DEF = 7;

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd1;

	localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd2;
	localparam logic [SC_W-1:0] SAMPLE_COUNT_RESET = 7'd16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SINIT,
		ST_TPREP,
		ST_TMUL,
		ST_TSTART,
		ST_TDIV,
		ST_TDONE,
		ST_MRD,
		ST_MMUL,
		ST_MADD,
		ST_OUT,
		ST_LRD,
		ST_LOUT
	} state_t;

	typedef struct packed {
		logic store;
		logic setup;
		logic clear_cnt;
		logic sinit;
		logic tprep;
		logic tmul;
		logic div_start;
		logic tdone;
		logic mrd;
		logic mmul;
		logic madd;
		logic load_sample;
		logic lrd;
		logic load_last;
	} cmd_t;

	typedef struct packed {
		logic no_output;
		logic k_zero;
		logic term_zero;
		logic div_done;
		logic div_busy;
		logic term_last;
		logic mac_end;
		logic sample_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/bcs_div.sv =====
module bcs_div #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== rtl/core/bcs_datapath.sv =====
module bcs_datapath #(
	parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
	parameter int MAX_DEGREE = bcs_pkg::MAX_DEGREE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bcs_pkg::cmd_t                 cmd,
	output bcs_pkg::status_t              sts,
	input  logic [bcs_pkg::DEG_W-1:0]     degree,
	input  logic [bcs_pkg::SC_W-1:0]      sample_count,
	input  logic [bcs_pkg::COORD_W-1:0]   in_x,
	input  logic [bcs_pkg::COORD_W-1:0]   in_y,
	input  logic [bcs_pkg::COORD_W-1:0]   in_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bcs_pkg::COORD_W-1:0]   out_x,
	output logic [bcs_pkg::COORD_W-1:0]   out_y,
	output logic [bcs_pkg::COORD_W-1:0]   out_z,
	output logic                          out_last
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int JW = $clog2(MAX_DEGREE + 1);
	localparam int MW = $clog2(MAX_POINTS + MAX_DEGREE + 2);
	localparam int KNW = $clog2(MAX_POINTS * (bcs_pkg::SC_MAX - 1) + 1);
	localparam int BW = bcs_pkg::BASIS_W;
	localparam int NW = KNW + BW + 1;
	localparam int RW = bcs_pkg::D_W + CW;
	localparam int XW = bcs_pkg::COORD_W;
	localparam int AC = bcs_pkg::ACC_W;
	localparam int SH_W = AC - bcs_pkg::BASIS_BITS;
	localparam int SC_W_LOC = bcs_pkg::SC_W;

	logic [XW-1:0] mem_x [MAX_POINTS];
	logic [XW-1:0] mem_y [MAX_POINTS];
	logic [XW-1:0] mem_z [MAX_POINTS];

	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            n_q;
	logic [JW-1:0]            k_q;
	logic [bcs_pkg::D_W-1:0]  d_q;
	logic [CW-1:0]            pw_q;
	logic [KNW-1:0]           u_q;
	logic [CW-1:0]            q_q;
	logic [bcs_pkg::D_W-1:0]  r_q;
	logic [bcs_pkg::D_W-1:0]  i_q;
	logic [JW-1:0]            j_q;
	logic [JW-1:0]            lvl_q;
	logic                     t_q;
	logic                     macend_q;
	logic [BW-1:0]            basis_q [MAX_DEGREE+1];
	logic [BW-1:0]            sum_q;
	logic [KNW-1:0]           a_q;
	logic [KNW-1:0]           den_q;
	logic [BW-1:0]            nb_q;
	logic                     zero_q;
	logic [NW-1:0]            num_q;
	logic signed [XW-1:0]     rd_x_q, rd_y_q, rd_z_q;
	logic signed [AC-1:0]     prod_x_q, prod_y_q, prod_z_q;
	logic signed [AC-1:0]     acc_x_q, acc_y_q, acc_z_q;
	logic                     out_valid_q;
	logic [XW-1:0]            out_x_q, out_y_q, out_z_q;
	logic                     out_last_q;

	logic [SC_W_LOC-1:0]      sc_cap;
	logic [CW-1:0]            n_new;
	logic [JW-1:0]            k_new;
	logic [31:0]              k_tmp;
	logic                     no_out;
	logic [MW-1:0]            m_idx, lo_idx, hi_idx;
	logic [KNW-1:0]           knot_lo, knot_hi;
	logic signed [KNW:0]      a_val;
	logic [KNW-1:0]           den_val;
	logic [BW-1:0]            nb_val;
	logic [AW-1:0]            raddr;
	logic [BW-1:0]            term;
	logic [BW-1:0]            new_basis;
	logic [RW-1:0]            r_sum;
	logic                     div_busy, div_done;
	logic [NW-1:0]            div_quot;
	logic                     free;

	function automatic logic [KNW-1:0] knot_at(input logic [MW-1:0] idx, input logic [JW-1:0] k,
			input logic [CW-1:0] n, input logic [bcs_pkg::D_W-1:0] d, input logic [CW-1:0] pw);
		logic [KNW-1:0] res;
		if (idx <= MW'(k)) begin
			res = '0;
		end else if (idx <= MW'(n)) begin
			res = KNW'(KNW'(idx - MW'(k)) * KNW'(d));
		end else begin
			res = KNW'(KNW'(pw) * KNW'(d));
		end
		return res;
	endfunction

	function automatic logic [XW-1:0] coord_out(input logic signed [AC-1:0] acc);
		logic [AC-1:0]          v;
		logic signed [SH_W-1:0] sh;
		logic [XW-1:0]          res;
		v = acc + (AC'(1) << (bcs_pkg::BASIS_BITS - 1));
		sh = SH_W'($signed(v) >>> bcs_pkg::BASIS_BITS);
		if (sh > $signed(SH_W'(32'h7FFF_FFFF))) begin
			res = 32'h7FFF_FFFF;
		end else if (sh < -$signed(SH_W'(33'h1_0000_0000 >> 1))) begin
			res = 32'h8000_0000;
		end else begin
			res = sh[XW-1:0];
		end
		return res;
	endfunction

	always_comb begin
		sc_cap = (sample_count > SC_W_LOC'(bcs_pkg::SC_MAX)) ? SC_W_LOC'(bcs_pkg::SC_MAX)
			: sample_count;
		no_out = 32'(sc_cap) <= 32'(cnt_q);
		n_new = cnt_q - 1'b1;
		k_tmp = (32'(degree) > 32'(MAX_DEGREE)) ? 32'(MAX_DEGREE) : 32'(degree);
		if (k_tmp > 32'(n_new)) begin
			k_tmp = 32'(n_new);
		end
		k_new = k_tmp[JW-1:0];
	end

	always_comb begin
		m_idx = MW'(q_q) + MW'(j_q);
		lo_idx = t_q ? m_idx + 1'b1 : m_idx;
		hi_idx = m_idx + MW'(lvl_q) + MW'(t_q);
		knot_lo = knot_at(lo_idx, k_q, n_q, d_q, pw_q);
		knot_hi = knot_at(hi_idx, k_q, n_q, d_q, pw_q);
		a_val = t_q ? $signed({1'b0, knot_hi}) - $signed({1'b0, u_q})
			: $signed({1'b0, u_q}) - $signed({1'b0, knot_lo});
		den_val = knot_hi - knot_lo;
		nb_val = t_q ? ((j_q == k_q) ? '0 : basis_q[1]) : basis_q[0];
		term = zero_q ? '0 : div_quot[BW-1:0];
		new_basis = sum_q + term;
		r_sum = RW'(r_q) + RW'(pw_q);
		raddr = cmd.lrd ? n_q[AW-1:0] : AW'(q_q + CW'(j_q));
		free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.store && cnt_q < CW'(MAX_POINTS)) begin
			mem_x[cnt_q[AW-1:0]] <= in_x;
			mem_y[cnt_q[AW-1:0]] <= in_y;
			mem_z[cnt_q[AW-1:0]] <= in_z;
		end
		if (cmd.mrd || cmd.lrd) begin
			rd_x_q <= mem_x[raddr];
			rd_y_q <= mem_y[raddr];
			rd_z_q <= mem_z[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			t_q <= 1'b0;
			j_q <= '0;
			lvl_q <= '0;
			macend_q <= 1'b0;
		end else begin
			if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (cmd.store && cnt_q < CW'(MAX_POINTS)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_sample || cmd.load_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.sinit) begin
				t_q <= 1'b0;
				j_q <= '0;
				lvl_q <= JW'(1);
			end else if (cmd.tdone) begin
				t_q <= !t_q;
				if (t_q) begin
					if (j_q == k_q) begin
						j_q <= '0;
						lvl_q <= lvl_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
			end else if (cmd.mmul) begin
				macend_q <= j_q == k_q;
				j_q <= (j_q == k_q) ? '0 : j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			n_q <= n_new;
			k_q <= k_new;
			d_q <= bcs_pkg::D_W'(sc_cap - 1'b1);
			pw_q <= n_new - CW'(k_new) + 1'b1;
			u_q <= '0;
			q_q <= '0;
			r_q <= '0;
			i_q <= '0;
		end
		if (cmd.load_sample) begin
			i_q <= i_q + 1'b1;
			u_q <= u_q + KNW'(pw_q);
			if (r_sum >= RW'(d_q)) begin
				r_q <= bcs_pkg::D_W'(r_sum - RW'(d_q));
				q_q <= q_q + 1'b1;
			end else begin
				r_q <= bcs_pkg::D_W'(r_sum);
			end
		end
		if (cmd.sinit) begin
			for (int i = 0; i <= MAX_DEGREE; i++) begin
				basis_q[i] <= (JW'(i) == k_q) ? (BW'(1) << bcs_pkg::BASIS_BITS) : '0;
			end
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else if ((cmd.tdone && t_q) || cmd.mmul) begin
			for (int i = 0; i < MAX_DEGREE; i++) begin
				basis_q[i] <= (JW'(i) == k_q) ? (cmd.mmul ? basis_q[0] : new_basis)
					: basis_q[i+1];
			end
			basis_q[MAX_DEGREE] <= cmd.mmul ? basis_q[0] : new_basis;
		end
		if (cmd.tdone && !t_q) begin
			sum_q <= term;
		end
		if (cmd.tprep) begin
			a_q <= a_val[KNW-1:0];
			den_q <= den_val;
			nb_q <= nb_val;
			zero_q <= den_val == '0 || a_val[KNW] || a_val == '0 || nb_val == '0;
		end
		if (cmd.tmul) begin
			num_q <= NW'(a_q) * NW'(nb_q) + NW'(den_q >> 1);
		end
		if (cmd.mmul) begin
			prod_x_q <= AC'(rd_x_q * $signed({1'b0, basis_q[0]}));
			prod_y_q <= AC'(rd_y_q * $signed({1'b0, basis_q[0]}));
			prod_z_q <= AC'(rd_z_q * $signed({1'b0, basis_q[0]}));
		end
		if (cmd.madd) begin
			acc_x_q <= acc_x_q + prod_x_q;
			acc_y_q <= acc_y_q + prod_y_q;
			acc_z_q <= acc_z_q + prod_z_q;
		end
		if (cmd.load_sample) begin
			out_x_q <= coord_out(acc_x_q);
			out_y_q <= coord_out(acc_y_q);
			out_z_q <= coord_out(acc_z_q);
			out_last_q <= 1'b0;
		end else if (cmd.load_last) begin
			out_x_q <= rd_x_q;
			out_y_q <= rd_y_q;
			out_z_q <= rd_z_q;
			out_last_q <= 1'b1;
		end
	end

	bcs_div #(
		.NUM_W(NW),
		.DEN_W(KNW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num_q),
		.den   (den_q),
		.busy  (div_busy),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		sts.no_output = no_out;
		sts.k_zero = k_q == '0;
		sts.term_zero = zero_q;
		sts.div_done = div_done;
		sts.div_busy = div_busy;
		sts.term_last = t_q && j_q == k_q && lvl_q == k_q;
		sts.mac_end = macend_q;
		sts.sample_last = (i_q + 1'b1) == d_q;
		sts.out_free = free;
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign out_last = out_last_q;

endmodule

// ===== rtl/core/bcs_ctrl.sv =====
module bcs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_last,
	output logic             in_ready,
	input  bcs_pkg::status_t sts,
	output bcs_pkg::cmd_t    cmd
);

	bcs_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			bcs_pkg::ST_IDLE: begin
				if (in_valid && in_last) state_nx = bcs_pkg::ST_SETUP;
			end
			bcs_pkg::ST_SETUP: begin
				state_nx = sts.no_output ? bcs_pkg::ST_IDLE : bcs_pkg::ST_SINIT;
			end
			bcs_pkg::ST_SINIT: begin
				state_nx = sts.k_zero ? bcs_pkg::ST_MRD : bcs_pkg::ST_TPREP;
			end
			bcs_pkg::ST_TPREP: state_nx = bcs_pkg::ST_TMUL;
			bcs_pkg::ST_TMUL: begin
				state_nx = sts.term_zero ? bcs_pkg::ST_TDONE : bcs_pkg::ST_TSTART;
			end
			bcs_pkg::ST_TSTART: state_nx = bcs_pkg::ST_TDIV;
			bcs_pkg::ST_TDIV: begin
				if (sts.div_done) state_nx = bcs_pkg::ST_TDONE;
			end
			bcs_pkg::ST_TDONE: begin
				state_nx = sts.term_last ? bcs_pkg::ST_MRD : bcs_pkg::ST_TPREP;
			end
			bcs_pkg::ST_MRD: state_nx = bcs_pkg::ST_MMUL;
			bcs_pkg::ST_MMUL: state_nx = bcs_pkg::ST_MADD;
			bcs_pkg::ST_MADD: begin
				state_nx = sts.mac_end ? bcs_pkg::ST_OUT : bcs_pkg::ST_MRD;
			end
			bcs_pkg::ST_OUT: begin
				if (sts.out_free) begin
					state_nx = sts.sample_last ? bcs_pkg::ST_LRD : bcs_pkg::ST_SINIT;
				end
			end
			bcs_pkg::ST_LRD: state_nx = bcs_pkg::ST_LOUT;
			bcs_pkg::ST_LOUT: begin
				if (sts.out_free) state_nx = bcs_pkg::ST_IDLE;
			end
			default: state_nx = bcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			bcs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.store = in_valid;
			end
			bcs_pkg::ST_SETUP: begin
				cmd.setup = 1'b1;
				cmd.clear_cnt = sts.no_output;
			end
			bcs_pkg::ST_SINIT: cmd.sinit = 1'b1;
			bcs_pkg::ST_TPREP: cmd.tprep = 1'b1;
			bcs_pkg::ST_TMUL: cmd.tmul = 1'b1;
			bcs_pkg::ST_TSTART: cmd.div_start = 1'b1;
			bcs_pkg::ST_TDIV: cmd = '0;
			bcs_pkg::ST_TDONE: cmd.tdone = 1'b1;
			bcs_pkg::ST_MRD: cmd.mrd = 1'b1;
			bcs_pkg::ST_MMUL: cmd.mmul = 1'b1;
			bcs_pkg::ST_MADD: cmd.madd = 1'b1;
			bcs_pkg::ST_OUT: cmd.load_sample = sts.out_free;
			bcs_pkg::ST_LRD: cmd.lrd = 1'b1;
			bcs_pkg::ST_LOUT: begin
				cmd.load_last = sts.out_free;
				cmd.clear_cnt = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/bspline_curve_sampler.sv =====
// Clamped uniform B-spline curve sampler.
// Control points enter on the slave stream one per transaction, x/y/z in
// tdata, with tlast on the final point of a curve. Up to MAX_POINTS points
// are stored, each as it is accepted. The tlast transaction starts
// evaluation, and the slave side stays not ready until the final result of
// that curve is loaded, or until setup ends when no results appear.
// Results leave on the master stream: sample_count-1 curve points (with
// sample_count capped at 64), then the last control point with tlast set.
// No results appear when sample_count does not exceed the point count.
// Each sample has an init step, 2k(k+1) basis-triangle terms, a read,
// multiply and add for each of the k+1 control points, and an output step.
// A nonzero term runs through the shared one-bit-per-cycle divider (44
// iterations at the default sizes); a zero term skips it. The divider sets
// the rate. Configuration writes are accepted at any time, but are
// only to be issued while the block is idle.
// When the receiver stalls, the result stays in the output register and the
// sequencer waits. Reset clears the point count and the output valid, and loads degree 2 and sample count 16.
module bspline_curve_sampler #(
	parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
	parameter int MAX_DEGREE = bcs_pkg::MAX_DEGREE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [95:0]                     s_axis_tdata,  // ctrl_x, ctrl_y, ctrl_z
	input  logic                            s_axis_tlast,  // final_point
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [95:0]                     m_axis_tdata,  // curve_x, curve_y, curve_z
	output logic                            m_axis_tlast,  // run_end
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic [bcs_pkg::DEG_W-1:0] degree_q;
	logic [bcs_pkg::SC_W-1:0]  sample_count_q;
	bcs_pkg::cmd_t             cmd;
	bcs_pkg::status_t          sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= bcs_pkg::DEGREE_RESET;
			sample_count_q <= bcs_pkg::SAMPLE_COUNT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == bcs_pkg::REG_DEGREE) begin
				degree_q <= cfg_data[bcs_pkg::DEG_W-1:0];
			end else if (cfg_index == bcs_pkg::REG_SAMPLE_COUNT) begin
				sample_count_q <= cfg_data[bcs_pkg::SC_W-1:0];
			end
		end
	end

	bcs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_last (s_axis_tlast),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bcs_datapath #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_DEGREE(MAX_DEGREE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.degree      (degree_q),
		.sample_count(sample_count_q),
		.in_x        (s_axis_tdata[31:0]),
		.in_y        (s_axis_tdata[63:32]),
		.in_z        (s_axis_tdata[95:64]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_x       (m_axis_tdata[31:0]),
		.out_y       (m_axis_tdata[63:32]),
		.out_z       (m_axis_tdata[95:64]),
		.out_last    (m_axis_tlast)
	);

	a_final_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input accepted right after the final point");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_sample || cmd.load_last) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten while stalled");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

endmodule
